// File: hw/rtl/gbpf_pkg.sv
// Shared types and request codes for the grid path finder.
`default_nettype none
package gbpf_pkg;
  typedef enum logic [2:0] {
    REQ_FIND       = 3'd0,
    REQ_SET_STAT   = 3'd1,
    REQ_CLR_STAT   = 3'd2,
    REQ_SET_MOV    = 3'd3,
    REQ_CLR_MOV    = 3'd4
  } req_type_t;

  localparam logic [1:0] CFG_COLS  = 2'd0;
  localparam logic [1:0] CFG_ROWS  = 2'd1;
  localparam logic [1:0] CFG_TW    = 2'd2;
  localparam logic [1:0] CFG_TH    = 2'd3;
  localparam int MAX_OUT = 64;
  localparam int GRID_W = 8;
  localparam int GRID_H = 8;
endpackage
`default_nettype wire

// File: hw/rtl/gbpf_req_if.sv
// Request, result and configuration channel interfaces.
`default_nettype none
interface gbpf_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [2:0] cell_col;
  logic [2:0] cell_row;
  logic [2:0] start_col;
  logic [2:0] start_row;
  logic [2:0] goal_col;
  logic [2:0] goal_row;
  modport source (output valid, req_type, cell_col, cell_row, start_col, start_row,
                  goal_col, goal_row, input ready);
  modport sink (input valid, req_type, cell_col, cell_row, start_col, start_row,
                goal_col, goal_row, output ready);
endinterface

interface gbpf_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] step_col;
  logic [2:0] step_row;
  logic       path_empty;
  logic       last_step;
  modport source (output valid, step_col, step_row, path_empty, last_step, input ready);
  modport sink (input valid, step_col, step_row, path_empty, last_step, output ready);
endinterface

interface gbpf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/grid_bfs_path_finder.sv
// Grid path finder top level: obstacle maps, BFS engine and path readout.
// Obstacle items are taken back to back while the finder is idle.
// A path item clears the visited map, expands the start and then each dequeued cell
// over its neighbours, then gives the result items one at a time, each held until
// res.ready; the queue and parent memories are read through registers.
// Synchronous reset clears the maps, queue and result valid, and restores the config.
`default_nettype none
module grid_bfs_path_finder
  import gbpf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  gbpf_req_if.sink    req,
  gbpf_res_if.source  res,
  gbpf_cfg_if.sink    cfg
);
  localparam int CELLS = GRID_W * GRID_H;
  localparam int CW = $clog2(GRID_W);
  localparam int RW = $clog2(GRID_H);
  localparam int AW = CW + RW;
  localparam int QW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_DEQ, S_WAITQ, S_NBR, S_BACK, S_BWAIT, S_EMIT, S_OUT
  } state_t;

  state_t state;
  logic [3:0] grid_cols, grid_rows;
  logic [6:0] tile_width, tile_height;
  logic [CELLS-1:0] static_blocked, movable_blocked, visited_mark;

  logic [AW-1:0] parent_mem [CELLS];
  logic [AW-1:0] queue_mem [CELLS];
  logic [AW-1:0] parent_rd, queue_rd;

  logic [QW-1:0] q_head, q_tail;
  logic [AW-1:0] clr_idx;
  logic [2:0] s_col, s_row, g_col, g_row;
  logic [2:0] c_col, c_row;
  logic [1:0] k;
  logic [6:0] n_out;
  logic start_in;

  // effective bounds
  logic [3:0] eff_c, eff_r;
  assign eff_c = (grid_cols < 4'(GRID_W)) ? grid_cols : 4'(GRID_W);
  assign eff_r = (grid_rows < 4'(GRID_H)) ? grid_rows : 4'(GRID_H);

  function automatic logic [AW-1:0] idx(input logic [2:0] c, input logic [2:0] r);
    return AW'(r) * AW'(GRID_W) + AW'(c);
  endfunction

  // neighbour candidate for step k in parity-adjusted order
  logic        par_even;
  logic [1:0]  dir;
  logic signed [4:0] nc, nr;
  logic        n_ok;
  logic [AW-1:0] n_idx;
  assign par_even = ~((c_col[0] & tile_width[0]) ^ (c_row[0] & tile_height[0]));

  always_comb begin
    dir = par_even ? 2'd3 - k : k;
    nc = 5'(c_col);
    nr = 5'(c_row);
    case (dir)
      2'd0: nc = 5'(c_col) + ((tile_width != 0) ? 5'sd1 : 5'sd0);
      2'd1: nc = 5'(c_col) - ((tile_width != 0) ? 5'sd1 : 5'sd0);
      2'd2: nr = 5'(c_row) - ((tile_height != 0) ? 5'sd1 : 5'sd0);
      default: nr = 5'(c_row) + ((tile_height != 0) ? 5'sd1 : 5'sd0);
    endcase
    n_idx = idx(nc[2:0], nr[2:0]);
    n_ok = !nc[4] && !nr[4] && (nc[3:0] < eff_c) && (nr[3:0] < eff_r);
    if (n_ok)
      n_ok = !static_blocked[n_idx] && !movable_blocked[n_idx] && !visited_mark[n_idx];
  end

  logic g_in;
  assign g_in = ({1'b0, g_col} < eff_c) && ({1'b0, g_row} < eff_r);
  assign start_in = ({1'b0, s_col} < eff_c) && ({1'b0, s_row} < eff_r);

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= 4'd8;
      grid_rows <= 4'd8;
      tile_width <= 7'd32;
      tile_height <= 7'd32;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_COLS: grid_cols <= cfg.data[3:0];
        CFG_ROWS: grid_rows <= cfg.data[3:0];
        CFG_TW:   tile_width <= cfg.data;
        CFG_TH:   tile_height <= cfg.data;
        default: ;
      endcase
    end
  end

  logic par_we, q_we;
  logic [AW-1:0] par_wa, par_ra, q_wa, q_ra;
  logic [AW-1:0] par_wd, q_wd;

  always_ff @(posedge clk) begin
    if (par_we) parent_mem[par_wa] <= par_wd;
    parent_rd <= parent_mem[par_ra];
    if (q_we) queue_mem[q_wa] <= q_wd;
    queue_rd <= queue_mem[q_ra];
  end

  always_comb begin
    par_we = 1'b0; par_wa = n_idx; par_wd = idx(c_col, c_row);
    q_we = 1'b0; q_wa = q_tail[AW-1:0]; q_wd = n_idx;
    q_ra = q_head[AW-1:0];
    par_ra = idx(c_col, c_row);
    if (state == S_NBR && n_ok && q_tail < QW'(CELLS)) begin
      par_we = 1'b1;
      q_we = 1'b1;
    end
  end

  // parent of the tile being emitted, and whether the walk ends after it
  logic [2:0] p_col, p_row;
  logic bt_last;
  assign p_col = 3'(parent_rd % AW'(GRID_W));
  assign p_row = 3'(parent_rd / AW'(GRID_W));
  assign bt_last = (n_out == 7'(MAX_OUT - 1)) ||
                   (p_col == s_col && p_row == s_row) ||
                   ({1'b0, p_col} >= eff_c) || ({1'b0, p_row} >= eff_r) ||
                   !visited_mark[parent_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      static_blocked <= '0;
      movable_blocked <= '0;
      visited_mark <= '0;
      res.valid <= 1'b0;
      q_head <= '0;
      q_tail <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (req.valid) begin
          if (req.req_type == REQ_FIND) begin
            s_col <= req.start_col; s_row <= req.start_row;
            g_col <= req.goal_col; g_row <= req.goal_row;
            clr_idx <= '0;
            state <= S_CLEAR;
          end else begin
            case (req.req_type)
              REQ_SET_STAT: static_blocked[idx(req.cell_col, req.cell_row)] <= 1'b1;
              REQ_CLR_STAT: static_blocked[idx(req.cell_col, req.cell_row)] <= 1'b0;
              REQ_SET_MOV:  movable_blocked[idx(req.cell_col, req.cell_row)] <= 1'b1;
              REQ_CLR_MOV:  movable_blocked[idx(req.cell_col, req.cell_row)] <= 1'b0;
              default: ;
            endcase
          end
        end
        S_CLEAR: begin
          visited_mark[clr_idx] <= start_in && (clr_idx == idx(s_col, s_row));
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(CELLS - 1)) begin
            c_col <= s_col; c_row <= s_row;
            q_head <= '0; q_tail <= '0;
            k <= '0;
            // start is expanded directly without queueing
            if (s_col == g_col && s_row == g_row) state <= S_BACK;
            else state <= S_NBR;
          end
        end
        S_DEQ: begin
          if (q_head >= q_tail) state <= S_BACK;
          else state <= S_WAITQ;
        end
        S_WAITQ: begin
          c_col <= 3'(queue_rd % AW'(GRID_W));
          c_row <= 3'(queue_rd / AW'(GRID_W));
          q_head <= q_head + 1'b1;
          k <= '0;
          if (3'(queue_rd % AW'(GRID_W)) == g_col && 3'(queue_rd / AW'(GRID_W)) == g_row)
            state <= S_BACK;
          else
            state <= S_NBR;
        end
        S_NBR: begin
          if (par_we) begin
            visited_mark[n_idx] <= 1'b1;
            q_tail <= q_tail + 1'b1;
          end
          k <= k + 1'b1;
          if (k == 2'd3) state <= S_DEQ;
        end
        S_BACK: begin
          c_col <= g_col; c_row <= g_row;
          n_out <= '0;
          if ((g_col == s_col && g_row == s_row) || !g_in || !visited_mark[idx(g_col, g_row)])
          begin
            res.step_col <= '0; res.step_row <= '0;
            res.path_empty <= 1'b1; res.last_step <= 1'b1;
            res.valid <= 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_BWAIT;
          end
        end
        // wait for the parent read of the current tile
        S_BWAIT: state <= S_EMIT;
        S_EMIT: begin
          res.step_col <= c_col; res.step_row <= c_row;
          res.path_empty <= 1'b0;
          res.last_step <= bt_last;
          n_out <= n_out + 1'b1;
          res.valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (res.ready) begin
          res.valid <= 1'b0;
          if (res.last_step) begin
            state <= S_IDLE;
          end else begin
            c_col <= p_col;
            c_row <= p_row;
            state <= S_BWAIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
